[design/qsfe_pkg.sv]
// Shared types and constants for the quadrilateral shape function evaluator.
package qsfe_pkg;

   localparam int FRAC_BITS = 14;
   localparam int OPW       = 20;   // operand width, holds sums of up to 3 Q14 coordinates
   localparam int MW        = 26;   // rounded product of two operands
   localparam int PW        = 28;   // second-level rounded product

   localparam logic [1:0] KIND_Q4   = 2'd0;
   localparam logic [1:0] KIND_Q8   = 2'd1;
   localparam logic [1:0] KIND_Q9   = 2'd2;
   localparam logic [1:0] KIND_NONE = 2'd3;

   localparam logic [3:0] LAST_Q4 = 4'd3;
   localparam logic [3:0] LAST_Q8 = 4'd7;
   localparam logic [3:0] LAST_Q9 = 4'd8;

   // out = round(round(k1 +/- round(a1*b1)) * b2) * round(c1*c2) >> (FRAC_BITS + extra)
   typedef struct packed {
      logic signed [OPW-1:0] a1;
      logic signed [OPW-1:0] b1;
      logic signed [OPW-1:0] k1;
      logic                  neg1;
      logic signed [OPW-1:0] b2;
      logic signed [OPW-1:0] c1;
      logic signed [OPW-1:0] c2;
      logic [1:0]            extra;
   } op_type;

endpackage

[design/qsfe_operand_sel.sv]
// Operand decoder: maps element kind and node to the three product-chain operand sets.
module qsfe_operand_sel (
   input  logic signed [15:0] xi_coord,
   input  logic signed [15:0] eta_coord,
   input  logic [1:0]         kind,
   input  logic [3:0]         node,
   output qsfe_pkg::op_type   shape_op,
   output qsfe_pkg::op_type   dxi_op,
   output qsfe_pkg::op_type   deta_op
);

   localparam int W = qsfe_pkg::OPW;
   localparam logic signed [W-1:0] U = W'(1) <<< qsfe_pkg::FRAC_BITS;

   logic signed [W-1:0] x, e, mx, me, x2, e2;
   logic signed [W-1:0] a, b, c, d, em, ep, xm, xp;
   logic signed [W-1:0] px, py, sxu, syu;
   logic                sx_neg, sy_neg;
   qsfe_pkg::op_type    dflt;

   assign x  = W'(xi_coord);
   assign e  = W'(eta_coord);
   assign mx = -x;
   assign me = -e;
   assign x2 = x <<< 1;
   assign e2 = e <<< 1;
   assign a  = U - x;
   assign b  = U + x;
   assign c  = U - e;
   assign d  = U + e;
   assign em = e - U;
   assign ep = e + U;
   assign xm = x - U;
   assign xp = x + U;

   // corner signs for the bilinear element
   assign sx_neg = (node == 4'd0) || (node == 4'd3);
   assign sy_neg = (node == 4'd0) || (node == 4'd1);
   assign px  = sx_neg ? a : b;
   assign py  = sy_neg ? c : d;
   assign sxu = sx_neg ? -U : U;
   assign syu = sy_neg ? -U : U;

   assign dflt = '{a1: '0, b1: U, k1: '0, neg1: 1'b0, b2: U, c1: U, c2: U, extra: 2'd0};

   always_comb begin
      shape_op = dflt;
      dxi_op   = dflt;
      deta_op  = dflt;
      unique case (kind)
         qsfe_pkg::KIND_Q4: begin
            shape_op.a1 = px;  shape_op.c1 = py;  shape_op.extra = 2'd2;
            dxi_op.a1   = py;  dxi_op.c1   = sxu; dxi_op.extra   = 2'd2;
            deta_op.a1  = px;  deta_op.c1  = syu; deta_op.extra  = 2'd2;
         end
         qsfe_pkg::KIND_Q8: begin
            unique case (node)
               4'd0, 4'd1, 4'd2, 4'd3: begin
                  shape_op.extra = 2'd2;
                  dxi_op.extra   = 2'd2;
                  deta_op.extra  = 2'd2;
                  shape_op.a1 = sx_neg ? a : b;
                  shape_op.b1 = sy_neg ? c : d;
                  shape_op.c1 = -U + (sx_neg ? mx : x) + (sy_neg ? me : e);
                  dxi_op.a1   = sy_neg ? c : d;
                  dxi_op.c1   = (sx_neg == sy_neg) ? x2 + e : x2 - e;
                  deta_op.a1  = sx_neg ? a : b;
                  deta_op.c1  = (sx_neg == sy_neg) ? e2 + x : e2 - x;
               end
               4'd4, 4'd6: begin
                  shape_op.k1 = U; shape_op.neg1 = 1'b1;
                  shape_op.a1 = x; shape_op.b1 = x;
                  shape_op.c1 = (node == 4'd4) ? c : d; shape_op.extra = 2'd1;
                  dxi_op.a1 = mx; dxi_op.b1 = (node == 4'd4) ? c : d;
                  deta_op.k1 = (node == 4'd4) ? -U : U;
                  deta_op.neg1 = (node == 4'd6);
                  deta_op.a1 = x; deta_op.b1 = x; deta_op.extra = 2'd1;
               end
               4'd5, 4'd7: begin
                  shape_op.k1 = U; shape_op.neg1 = 1'b1;
                  shape_op.a1 = e; shape_op.b1 = e;
                  shape_op.c1 = (node == 4'd5) ? b : a; shape_op.extra = 2'd1;
                  dxi_op.k1 = (node == 4'd5) ? U : -U;
                  dxi_op.neg1 = (node == 4'd5);
                  dxi_op.a1 = e; dxi_op.b1 = e; dxi_op.extra = 2'd1;
                  deta_op.a1 = me; deta_op.b1 = (node == 4'd5) ? b : a;
               end
               default: begin
               end
            endcase
         end
         qsfe_pkg::KIND_Q9: begin
            unique case (node)
               4'd0, 4'd1, 4'd2, 4'd3: begin
                  shape_op.a1 = e; shape_op.b1 = x;
                  shape_op.b2 = sy_neg ? em : ep;
                  shape_op.c1 = sx_neg ? xm : xp; shape_op.extra = 2'd2;
                  dxi_op.a1 = e; dxi_op.b1 = sy_neg ? em : ep;
                  dxi_op.c1 = sx_neg ? x2 - U : x2 + U; dxi_op.extra = 2'd2;
                  deta_op.a1 = x; deta_op.b1 = sy_neg ? e2 - U : e2 + U;
                  deta_op.c1 = sx_neg ? xm : xp; deta_op.extra = 2'd2;
               end
               4'd4, 4'd6: begin
                  shape_op.a1 = me; shape_op.b1 = (node == 4'd4) ? em : ep;
                  shape_op.c1 = xm; shape_op.c2 = xp; shape_op.extra = 2'd1;
                  dxi_op.neg1 = 1'b1; dxi_op.a1 = e; dxi_op.b1 = x;
                  dxi_op.b2 = (node == 4'd4) ? em : ep;
                  deta_op.a1 = (node == 4'd4) ? U - e2 : -U - e2;
                  deta_op.c1 = xm; deta_op.c2 = xp; deta_op.extra = 2'd1;
               end
               4'd5, 4'd7: begin
                  shape_op.a1 = em; shape_op.b1 = ep; shape_op.b2 = mx;
                  shape_op.c1 = (node == 4'd5) ? xp : xm; shape_op.extra = 2'd1;
                  dxi_op.neg1 = 1'b1; dxi_op.a1 = em; dxi_op.b1 = ep;
                  dxi_op.c1 = (node == 4'd5) ? x2 + U : x2 - U; dxi_op.extra = 2'd1;
                  deta_op.neg1 = 1'b1; deta_op.a1 = e; deta_op.b1 = x;
                  deta_op.b2 = (node == 4'd5) ? xp : xm;
               end
               4'd8: begin
                  shape_op.a1 = em; shape_op.b1 = ep;
                  shape_op.c1 = xm; shape_op.c2 = xp;
                  dxi_op.a1 = em; dxi_op.b1 = ep; dxi_op.c1 = x2;
                  deta_op.a1 = e2; deta_op.c1 = xm; deta_op.c2 = xp;
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

endmodule

[design/qsfe_node_lane.sv]
// One arithmetic lane: three-stage product chain with rounding and saturation.
module qsfe_node_lane (
   input  logic                clock,
   input  qsfe_pkg::op_type    op,
   output logic signed [16:0]  result
);

   localparam int FB  = qsfe_pkg::FRAC_BITS;
   localparam int W   = qsfe_pkg::OPW;
   localparam int MW  = qsfe_pkg::MW;
   localparam int PW  = qsfe_pkg::PW;
   localparam int P1W = 2 * W + 1;
   localparam int P2W = MW + 1 + W + 1;
   localparam int P3W = PW + MW + 1;

   // stage 1
   logic signed [P1W-1:0] prod_a, prod_c;
   logic signed [MW-1:0]  m1_ff, q1_ff;
   logic signed [W-1:0]   k1_ff, b2_ff;
   logic                  neg1_ff;
   logic [1:0]            ex1_ff;
   // stage 2
   logic signed [MW:0]    p1;
   logic signed [P2W-1:0] prod_b;
   logic signed [PW-1:0]  p2_ff;
   logic signed [MW-1:0]  q2_ff;
   logic [1:0]            ex2_ff;
   // stage 3
   logic signed [P3W-1:0] prod_f, rnd_f;
   logic signed [P3W-1:0] res_f;
   logic signed [16:0]    res_in;

   assign prod_a = P1W'(op.a1) * P1W'(op.b1) + (P1W'(1) <<< (FB - 1));
   assign prod_c = P1W'(op.c1) * P1W'(op.c2) + (P1W'(1) <<< (FB - 1));

   always_ff @(posedge clock) begin
      m1_ff   <= MW'(prod_a >>> FB);
      q1_ff   <= MW'(prod_c >>> FB);
      k1_ff   <= op.k1;
      neg1_ff <= op.neg1;
      b2_ff   <= op.b2;
      ex1_ff  <= op.extra;
   end

   assign p1     = neg1_ff ? (MW+1)'(k1_ff) - (MW+1)'(m1_ff)
                           : (MW+1)'(k1_ff) + (MW+1)'(m1_ff);
   assign prod_b = P2W'(p1) * P2W'(b2_ff) + (P2W'(1) <<< (FB - 1));

   always_ff @(posedge clock) begin
      p2_ff  <= PW'(prod_b >>> FB);
      q2_ff  <= q1_ff;
      ex2_ff <= ex1_ff;
   end

   assign prod_f = P3W'(p2_ff) * P3W'(q2_ff);

   always_comb begin
      rnd_f = prod_f + (P3W'(1) <<< (FB - 1));
      res_f = rnd_f >>> FB;
      case (ex2_ff)
         2'd1: begin
            rnd_f = prod_f + (P3W'(1) <<< FB);
            res_f = rnd_f >>> (FB + 1);
         end
         2'd2: begin
            rnd_f = prod_f + (P3W'(1) <<< (FB + 1));
            res_f = rnd_f >>> (FB + 2);
         end
         default: begin
         end
      endcase
      if (res_f > P3W'(65535)) begin
         res_in = 17'sd65535;
      end else if (res_f < -P3W'(65536)) begin
         res_in = -17'sd65536;
      end else begin
         res_in = res_f[16:0];
      end
   end

   always_ff @(posedge clock) begin
      result <= res_in;
   end

endmodule

[design/quad_shape_function_eval.sv]
// Top level: node sequencer, operand register and three arithmetic lanes.
// The first node result passes through the operand register and the lane registers.
// Throughput: one node result per cycle; a transaction yields 4, 8 or 9
//   node results (bilinear, serendipity, Lagrange); element kind 3 yields no result.
// The sequencer issues one node per cycle; the next transaction is taken while its
//   last node issues, so coordinates stream with no gap. The receiver cannot stall.
// Reset (synchronous): element kind returns to bilinear, pipeline valids clear.
module quad_shape_function_eval (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_wr_data,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_xi_coord,
   input  logic signed [15:0] req_eta_coord,
   output logic               rsp_valid,
   output logic [3:0]         rsp_node_index,
   output logic signed [16:0] rsp_shape_value,
   output logic signed [16:0] rsp_deriv_xi,
   output logic signed [16:0] rsp_deriv_eta,
   output logic               rsp_last_node
);

   // configuration
   logic [1:0] kind_ff;

   // node sequencer: holds the current transaction's coordinates
   logic               act_ff;
   logic [1:0]         seq_kind_ff;
   logic [3:0]         node_ff;
   logic [3:0]         last_idx_ff;
   logic [3:0]         last_idx_in;
   logic signed [15:0] x_ff, e_ff;
   logic               accept;
   logic               issue_last;

   // operand stage
   qsfe_pkg::op_type shape_op, dxi_op, deta_op;
   qsfe_pkg::op_type shape_op_ff, dxi_op_ff, deta_op_ff;

   // metadata travels alongside the lane stages (S0..S3)
   logic [3:0] vld_ff;
   logic [3:0] node_pipe_ff [4];
   logic [3:0] last_pipe_ff;

   assign issue_last = (node_ff == last_idx_ff);
   assign busy       = act_ff && !issue_last;
   assign accept     = start && !busy;

   always_comb begin
      case (kind_ff)
         qsfe_pkg::KIND_Q4: last_idx_in = qsfe_pkg::LAST_Q4;
         qsfe_pkg::KIND_Q8: last_idx_in = qsfe_pkg::LAST_Q8;
         default:           last_idx_in = qsfe_pkg::LAST_Q9;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= qsfe_pkg::KIND_Q4;
         act_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            kind_ff <= csr_wr_data;
         end
         if (accept) begin
            // unused kind takes the transaction and emits nothing
            act_ff <= (kind_ff != qsfe_pkg::KIND_NONE);
         end else if (act_ff && issue_last) begin
            act_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff        <= req_xi_coord;
         e_ff        <= req_eta_coord;
         seq_kind_ff <= kind_ff;
         last_idx_ff <= last_idx_in;
         node_ff     <= 4'd0;
      end else if (act_ff) begin
         node_ff <= node_ff + 4'd1;
      end
   end

   qsfe_operand_sel u_sel (
      .xi_coord  (x_ff),
      .eta_coord (e_ff),
      .kind      (seq_kind_ff),
      .node      (node_ff),
      .shape_op  (shape_op),
      .dxi_op    (dxi_op),
      .deta_op   (deta_op)
   );

   always_ff @(posedge clock) begin
      shape_op_ff <= shape_op;
      dxi_op_ff   <= dxi_op;
      deta_op_ff  <= deta_op;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[2:0], act_ff};
      end
   end

   always_ff @(posedge clock) begin
      node_pipe_ff[0] <= node_ff;
      node_pipe_ff[1] <= node_pipe_ff[0];
      node_pipe_ff[2] <= node_pipe_ff[1];
      node_pipe_ff[3] <= node_pipe_ff[2];
      last_pipe_ff    <= {last_pipe_ff[2:0], issue_last};
   end

   qsfe_node_lane u_lane_shape (
      .clock  (clock),
      .op     (shape_op_ff),
      .result (rsp_shape_value)
   );

   qsfe_node_lane u_lane_dxi (
      .clock  (clock),
      .op     (dxi_op_ff),
      .result (rsp_deriv_xi)
   );

   qsfe_node_lane u_lane_deta (
      .clock  (clock),
      .op     (deta_op_ff),
      .result (rsp_deriv_eta)
   );

   assign rsp_valid      = vld_ff[3];
   assign rsp_node_index = node_pipe_ff[3];
   assign rsp_last_node  = last_pipe_ff[3];

endmodule

[bench/tb_quad_shape_function_eval.sv]
// Self-checking testbench for the quadrilateral shape function evaluator.
`timescale 1ns / 1ps

module tb_quad_shape_function_eval;

   localparam int      U         = 1 << qsfe_pkg::FRAC_BITS;
   localparam longint  MAX_CYC   = 400000;
   localparam int      DRAIN_CYC = 12;   // pipeline depth plus margin

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic [1:0]         csr_wr_data = '0;
   logic               start = 1'b0;
   logic               busy;
   logic signed [15:0] req_xi_coord = '0;
   logic signed [15:0] req_eta_coord = '0;
   logic               rsp_valid;
   logic [3:0]         rsp_node_index;
   logic signed [16:0] rsp_shape_value;
   logic signed [16:0] rsp_deriv_xi;
   logic signed [16:0] rsp_deriv_eta;
   logic               rsp_last_node;

   quad_shape_function_eval u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .start           (start),
      .busy            (busy),
      .req_xi_coord    (req_xi_coord),
      .req_eta_coord   (req_eta_coord),
      .rsp_valid       (rsp_valid),
      .rsp_node_index  (rsp_node_index),
      .rsp_shape_value (rsp_shape_value),
      .rsp_deriv_xi    (rsp_deriv_xi),
      .rsp_deriv_eta   (rsp_deriv_eta),
      .rsp_last_node   (rsp_last_node)
   );

   always #5 clock = ~clock;

   // one node result
   typedef struct packed {
      logic [3:0]         node;
      logic signed [16:0] shape;
      logic signed [16:0] dxi;
      logic signed [16:0] deta;
      logic               last;
   } node_rslt_type;

   node_rslt_type node_q[$];
   logic [1:0] kind_shadow;   // predictor's copy of the element kind register
   int         n_errors = 0;
   longint     cycle_cnt = 0;

   // ---------------------------------------------------------------
   // Fixed-point helpers: round half up after a right shift
   // ---------------------------------------------------------------
   function automatic longint round_shr(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint qmul(longint a, longint b, int extra);
      return round_shr(a * b, qsfe_pkg::FRAC_BITS + extra);
   endfunction

   function automatic logic signed [16:0] clamp17(longint v);
      if (v > 65535) return 17'sd65535;
      if (v < -65536) return -17'sd65536;
      return v[16:0];
   endfunction

   // Work out all node results for one coordinate pair, queue them.
   task automatic predict_nodes(logic signed [15:0] xi_in, logic signed [15:0] eta_in);
      longint x, e, n[9], dx[9], de[9];
      longint a, b, c, d, qx, qe;
      longint em, ep, xm, xp, ex, xx, ee, eem, eep, xsm, xsp;
      longint sx, sy, px, py;
      int cnt;
      node_rslt_type r;
      x = xi_in;
      e = eta_in;
      cnt = 0;
      case (kind_shadow)
         qsfe_pkg::KIND_Q4: begin
            for (int k = 0; k < 4; k++) begin
               sx = (k == 1 || k == 2) ? 1 : -1;
               sy = (k >= 2) ? 1 : -1;
               px = U + sx * x;
               py = U + sy * e;
               n[k]  = qmul(px, py, 2);
               dx[k] = qmul(py, sx * U, 2);
               de[k] = qmul(px, sy * U, 2);
            end
            cnt = 4;
         end
         qsfe_pkg::KIND_Q8: begin
            a = U - x; b = U + x; c = U - e; d = U + e;
            qx = U - qmul(x, x, 0);
            qe = U - qmul(e, e, 0);
            n[0] = qmul(qmul(a, c, 0), -U - x - e, 2);
            n[1] = qmul(qmul(b, c, 0), -U + x - e, 2);
            n[2] = qmul(qmul(b, d, 0), -U + x + e, 2);
            n[3] = qmul(qmul(a, d, 0), -U - x + e, 2);
            n[4] = qmul(qx, c, 1);
            n[5] = qmul(qe, b, 1);
            n[6] = qmul(qx, d, 1);
            n[7] = qmul(qe, a, 1);
            dx[0] = qmul(c, 2 * x + e, 2);
            dx[1] = qmul(c, 2 * x - e, 2);
            dx[2] = qmul(d, 2 * x + e, 2);
            dx[3] = qmul(d, 2 * x - e, 2);
            dx[4] = qmul(-x, c, 0);
            dx[5] = round_shr(qe, 1);
            dx[6] = qmul(-x, d, 0);
            dx[7] = round_shr(-qe, 1);
            de[0] = qmul(a, 2 * e + x, 2);
            de[1] = qmul(b, 2 * e - x, 2);
            de[2] = qmul(b, 2 * e + x, 2);
            de[3] = qmul(a, 2 * e - x, 2);
            de[4] = round_shr(-qx, 1);
            de[5] = qmul(-e, b, 0);
            de[6] = round_shr(qx, 1);
            de[7] = qmul(-e, a, 0);
            cnt = 8;
         end
         qsfe_pkg::KIND_Q9: begin
            em = e - U; ep = e + U; xm = x - U; xp = x + U;
            ex = qmul(e, x, 0);
            xx = qmul(xm, xp, 0);
            ee = qmul(em, ep, 0);
            eem = qmul(e, em, 0);
            eep = qmul(e, ep, 0);
            xsm = qmul(x, 2 * e - U, 0);
            xsp = qmul(x, 2 * e + U, 0);
            n[0] = qmul(qmul(ex, em, 0), xm, 2);
            n[1] = qmul(qmul(ex, em, 0), xp, 2);
            n[2] = qmul(qmul(ex, ep, 0), xp, 2);
            n[3] = qmul(qmul(ex, ep, 0), xm, 2);
            n[4] = qmul(qmul(-e, em, 0), xx, 1);
            n[5] = qmul(qmul(-x, ee, 0), xp, 1);
            n[6] = qmul(qmul(-e, ep, 0), xx, 1);
            n[7] = qmul(qmul(-x, ee, 0), xm, 1);
            n[8] = qmul(ee, xx, 0);
            dx[0] = qmul(eem, 2 * x - U, 2);
            dx[1] = qmul(eem, 2 * x + U, 2);
            dx[2] = qmul(eep, 2 * x + U, 2);
            dx[3] = qmul(eep, 2 * x - U, 2);
            dx[4] = qmul(-ex, em, 0);
            dx[5] = qmul(-ee, 2 * x + U, 1);
            dx[6] = qmul(-ex, ep, 0);
            dx[7] = qmul(-ee, 2 * x - U, 1);
            dx[8] = qmul(2 * x, ee, 0);
            de[0] = qmul(xsm, xm, 2);
            de[1] = qmul(xsm, xp, 2);
            de[2] = qmul(xsp, xp, 2);
            de[3] = qmul(xsp, xm, 2);
            de[4] = qmul(U - 2 * e, xx, 1);
            de[5] = qmul(-ex, xp, 0);
            de[6] = qmul(-U - 2 * e, xx, 1);
            de[7] = qmul(-ex, xm, 0);
            de[8] = qmul(2 * e, xx, 0);
            cnt = 9;
         end
         default: cnt = 0;   // unused kind: no output at all
      endcase
      for (int k = 0; k < cnt; k++) begin
         r.node  = k[3:0];
         r.shape = clamp17(n[k]);
         r.dxi   = clamp17(dx[k]);
         r.deta  = clamp17(de[k]);
         r.last  = (k == cnt - 1);
         node_q.push_back(r);
      end
   endtask

   task automatic report_mismatch(string what);
      n_errors++;
      $display("ERROR @%0t: %s", $time, what);
   endtask

   // ---------------------------------------------------------------
   // Result checker: every strobe is compared against the oldest expectation
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      node_rslt_type want;
      if (!reset && rsp_valid) begin
         if (node_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result, node %0d", rsp_node_index));
         end else begin
            want = node_q.pop_front();
            if (rsp_node_index !== want.node)
               report_mismatch($sformatf("node_index %0d, want %0d",
                                         rsp_node_index, want.node));
            if (rsp_shape_value !== want.shape)
               report_mismatch($sformatf("node %0d shape %0d, want %0d",
                                         want.node, rsp_shape_value, want.shape));
            if (rsp_deriv_xi !== want.dxi)
               report_mismatch($sformatf("node %0d dxi %0d, want %0d",
                                         want.node, rsp_deriv_xi, want.dxi));
            if (rsp_deriv_eta !== want.deta)
               report_mismatch($sformatf("node %0d deta %0d, want %0d",
                                         want.node, rsp_deriv_eta, want.deta));
            if (rsp_last_node !== want.last)
               report_mismatch($sformatf("node %0d last %0b, want %0b",
                                         want.node, rsp_last_node, want.last));
         end
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= MAX_CYC) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   // Directed rows. chk_n0 marks rows where node 0 is typed in by hand
   // (corners and center, where the answer is plain); the predictor covers
   // every node anyway and the hand value cross-checks node 0.
   typedef struct {
      logic [1:0]         kind;
      logic signed [15:0] xi;
      logic signed [15:0] eta;
      logic               chk_n0;
      logic signed [16:0] n0_shape;
   } dir_row_type;

   dir_row_type dir_tbl[$];
   logic        no_idle;   // a stretch where the sender never pauses

   // Send one coordinate pair; start held until the accepting edge.
   task automatic send_coord(logic signed [15:0] xi, logic signed [15:0] eta);
      if (!no_idle) begin
         while ($urandom_range(99) < 26) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start         <= 1'b1;
      req_xi_coord  <= xi;
      req_eta_coord <= eta;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_nodes(xi, eta);
   endtask

   // Wait until no node result is outstanding, then let the pipe drain.
   task automatic drain_pipe();
      start <= 1'b0;
      while (node_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
   endtask

   // Register write only while the block is idle.
   task automatic write_kind(logic [1:0] k);
      drain_pipe();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= k;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      kind_shadow = k;
   endtask

   function automatic logic signed [15:0] rand_coord();
      case ($urandom_range(9))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'sd0;
         3: return 16'(-32768 + $urandom_range(65535));   // out of the natural range
         default: return 16'($urandom_range(32768) - 16384);
      endcase
   endfunction

   initial begin
      logic [1:0] kind_now;
      node_rslt_type hand;
      no_idle = 1'b0;
      kind_shadow = qsfe_pkg::KIND_Q4;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // bilinear right after reset; corner nodes hit 1.0 at their own corner
      dir_tbl.push_back('{qsfe_pkg::KIND_Q4, -16'sd16384, -16'sd16384, 1'b1, 17'sd16384});
      dir_tbl.push_back('{qsfe_pkg::KIND_Q4, 16'sd16384, 16'sd16384, 1'b1, 17'sd0});
      dir_tbl.push_back('{qsfe_pkg::KIND_Q4, 16'sd0, 16'sd0, 1'b1, 17'sd4096});
      dir_tbl.push_back('{qsfe_pkg::KIND_Q4, 16'sh7fff, 16'sh8000, 1'b0, 17'sd0});
      dir_tbl.push_back('{qsfe_pkg::KIND_Q4, 16'sh8000, 16'sh7fff, 1'b0, 17'sd0});
      dir_tbl.push_back('{qsfe_pkg::KIND_Q8, -16'sd16384, -16'sd16384, 1'b1, 17'sd16384});
      dir_tbl.push_back('{qsfe_pkg::KIND_Q8, 16'sd0, 16'sd0, 1'b1, -17'sd4096});
      dir_tbl.push_back('{qsfe_pkg::KIND_Q8, 16'sd16384, -16'sd16384, 1'b0, 17'sd0});
      dir_tbl.push_back('{qsfe_pkg::KIND_Q8, 16'sh7fff, 16'sh7fff, 1'b0, 17'sd0});
      dir_tbl.push_back('{qsfe_pkg::KIND_Q8, 16'sh8000, 16'sh8000, 1'b0, 17'sd0});
      dir_tbl.push_back('{qsfe_pkg::KIND_Q9, -16'sd16384, -16'sd16384, 1'b1, 17'sd16384});
      dir_tbl.push_back('{qsfe_pkg::KIND_Q9, 16'sd0, 16'sd0, 1'b1, 17'sd0});
      dir_tbl.push_back('{qsfe_pkg::KIND_Q9, 16'sd8192, -16'sd8192, 1'b0, 17'sd0});
      dir_tbl.push_back('{qsfe_pkg::KIND_Q9, 16'sh7fff, 16'sh8000, 1'b0, 17'sd0});
      dir_tbl.push_back('{qsfe_pkg::KIND_Q9, 16'sh8000, 16'sh8000, 1'b0, 17'sd0});
      dir_tbl.push_back('{qsfe_pkg::KIND_NONE, 16'sd1234, -16'sd77, 1'b0, 17'sd0});
      dir_tbl.push_back('{qsfe_pkg::KIND_NONE, 16'sh7fff, 16'sh8000, 1'b0, 17'sd0});
      dir_tbl.push_back('{qsfe_pkg::KIND_Q4, 16'sd5555, -16'sd3333, 1'b0, 17'sd0});

      kind_now = qsfe_pkg::KIND_Q4;
      foreach (dir_tbl[i]) begin
         if (dir_tbl[i].kind != kind_now) begin
            write_kind(dir_tbl[i].kind);
            kind_now = dir_tbl[i].kind;
         end
         send_coord(dir_tbl[i].xi, dir_tbl[i].eta);
         if (dir_tbl[i].chk_n0) begin
            hand = node_q[node_q.size() - ((kind_now == qsfe_pkg::KIND_Q4) ? 4 :
                                           (kind_now == qsfe_pkg::KIND_Q8) ? 8 : 9)];
            if (hand.shape !== dir_tbl[i].n0_shape)
               report_mismatch($sformatf("row %0d predicted node 0 shape %0d, want %0d",
                                         i, hand.shape, dir_tbl[i].n0_shape));
         end
      end

      // random phases, extremes of the register included
      for (int ph = 0; ph < 8; ph++) begin
         write_kind((ph == 7) ? qsfe_pkg::KIND_NONE : 2'($urandom_range(2)));
         no_idle = (ph == 3);   // back-to-back stretch
         for (int i = 0; i < 14; i++) begin
            send_coord(rand_coord(), rand_coord());
            // hold-off: sender waits for every outstanding result
            if (ph == 1 && i == 6) drain_pipe();
         end
      end
      no_idle = 1'b0;

      drain_pipe();
      if (n_errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[sim.f]
design/qsfe_pkg.sv
design/qsfe_operand_sel.sv
design/qsfe_node_lane.sv
design/quad_shape_function_eval.sv
bench/tb_quad_shape_function_eval.sv
